@@ hw/rtl/svnb_pkg.sv @@
`timescale 1ns / 1ps
package svnb_pkg;

  localparam int VERTEX_COUNT_DEF = 1024;
  localparam int COORD_BITS_DEF   = 16;
  localparam int ACCUM_BITS_DEF   = 48;

  localparam int INDEX_W  = 10;
  localparam int CMD_W    = 2;
  localparam int NORMAL_W = 16;
  localparam int NORM_BITS = 30;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE    = 2'd0,
    CMD_TRIANGLE = 2'd1,
    CMD_READ     = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

endpackage

@@ hw/rtl/svnb_ram.sv @@
`timescale 1ns / 1ps
module svnb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/smooth_vertex_normal_builder.sv @@
// Smooth vertex normal builder. One item is taken at a time; in_ready is high only while
// the sequencer is idle. A vertex write is stored as it is accepted. A triangle makes three
// position reads, six products through the single shared multiplier, then a read and a
// saturating write of the accumulator memory for each corner in turn. A normal read runs
// the range shift (one bit a cycle), the bit-serial square root and the restoring divider
// for each component; a zero accumulator skips the divider. A clear command, and the
// clearing pass after reset, sweep the accumulator memory one entry a cycle, with
// in_ready low. A finished normal waits until the output register is free, then moves
// into it and the block goes back to idle.
`timescale 1ns / 1ps
module smooth_vertex_normal_builder #(
  parameter int VERTEX_COUNT = svnb_pkg::VERTEX_COUNT_DEF,
  parameter int COORD_BITS   = svnb_pkg::COORD_BITS_DEF,
  parameter int ACCUM_BITS   = svnb_pkg::ACCUM_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [svnb_pkg::CMD_W-1:0]          in_command,
  input  logic [svnb_pkg::INDEX_W-1:0]        in_index_a,
  input  logic [svnb_pkg::INDEX_W-1:0]        in_index_b,
  input  logic [svnb_pkg::INDEX_W-1:0]        in_index_c,
  input  logic signed [COORD_BITS-1:0]        in_pos_x,
  input  logic signed [COORD_BITS-1:0]        in_pos_y,
  input  logic signed [COORD_BITS-1:0]        in_pos_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [svnb_pkg::INDEX_W-1:0]        out_vertex_index,
  output logic signed [svnb_pkg::NORMAL_W-1:0] out_normal_x,
  output logic signed [svnb_pkg::NORMAL_W-1:0] out_normal_y,
  output logic signed [svnb_pkg::NORMAL_W-1:0] out_normal_z
);

  import svnb_pkg::*;

  localparam int AW     = $clog2(VERTEX_COUNT);
  localparam int CW     = COORD_BITS;
  localparam int DW     = CW + 1;
  localparam int FN_W   = 2 * DW + 1;
  localparam int MUL_W  = (DW > NORM_BITS + 1) ? DW : NORM_BITS + 1;
  localparam int PW     = 2 * MUL_W;
  localparam int SQ_W   = 2 * NORM_BITS + 2;
  localparam int SUM_W  = ((FN_W > ACCUM_BITS) ? FN_W : ACCUM_BITS) + 1;
  localparam int LEN_W  = NORM_BITS + 1;
  localparam int STEP_W = $clog2(NORM_BITS + 1);
  localparam int A      = ACCUM_BITS;

  localparam logic signed [SUM_W-1:0] ACC_HI =
    $signed({{(SUM_W-A+1){1'b0}}, {(A-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] ACC_LO = -ACC_HI - SUM_W'(1);

  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001,
    S_IDLE  = 16'h0002,
    S_TRA   = 16'h0004,
    S_TRB   = 16'h0008,
    S_TRC   = 16'h0010,
    S_TV    = 16'h0020,
    S_MUL   = 16'h0040,
    S_ARD   = 16'h0080,
    S_AWR   = 16'h0100,
    S_RACC  = 16'h0200,
    S_RMAG  = 16'h0400,
    S_RSH   = 16'h0800,
    S_RSQ   = 16'h1000,
    S_RSQRT = 16'h2000,
    S_RDIV  = 16'h4000,
    S_RFIN  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        comp_r, comp_nxt;
  logic [INDEX_W-1:0] ia_r, ib_r, ic_r, ia_nxt, ib_nxt, ic_nxt;
  logic signed [CW-1:0] pax_r, pay_r, paz_r, pax_nxt, pay_nxt, paz_nxt;
  logic signed [DW-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [DW-1:0] ux_nxt, uy_nxt, uz_nxt, vx_nxt, vy_nxt, vz_nxt;
  logic signed [FN_W-1:0] fn_r [3];
  logic signed [FN_W-1:0] fn_nxt [3];
  logic [A-1:0] mag_r [3];
  logic [A-1:0] mag_nxt [3];
  logic [2:0]   neg_r, neg_nxt;
  logic [A-1:0] mmax_r, mmax_nxt;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PW-1:0]    prod_r, prod_nxt;
  logic [SQ_W-1:0] sq_r, sq_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [LEN_W-1:0] len_r, len_nxt, rem_r, rem_nxt;
  logic [NORMAL_W-1:0] q_r, q_nxt;
  logic [NORMAL_W-1:0] res_r [3];
  logic [NORMAL_W-1:0] res_nxt [3];
  logic out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0] out_idx_r, out_idx_nxt;
  logic [NORMAL_W-1:0] out_x_r, out_y_r, out_z_r, out_x_nxt, out_y_nxt, out_z_nxt;

  logic              pos_we;
  logic [AW-1:0]     pos_waddr, pos_raddr;
  logic [3*CW-1:0]   pos_wdata, pos_rd;
  logic              acc_we;
  logic [AW-1:0]     acc_waddr, acc_raddr;
  logic [3*A-1:0]    acc_wdata, acc_rd;

  logic accept;
  logic a_ok, b_ok, c_ok;
  logic [AW-1:0] corner_addr;
  logic signed [CW-1:0] rd_x, rd_y, rd_z;
  logic signed [A-1:0]  acc_c [3];
  logic signed [SUM_W-1:0] sat_sum [3];
  logic [A-1:0] sat_res [3];
  logic [STEP_W-1:0] step_m1;
  logic [1:0] fn_sel;
  logic [SQ_W-1:0] sqrt_t;
  logic [LEN_W:0] div_t;
  logic div_ge;
  logic [NORMAL_W-1:0] q_sat;

  svnb_ram #(.WIDTH(3 * CW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rd)
  );

  svnb_ram #(.WIDTH(3 * A), .DEPTH(VERTEX_COUNT)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rd)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign accept           = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_idx_r;
  assign out_normal_x     = $signed(out_x_r);
  assign out_normal_y     = $signed(out_y_r);
  assign out_normal_z     = $signed(out_z_r);

  assign a_ok = (32'(in_index_a) < VERTEX_COUNT);
  assign b_ok = (32'(in_index_b) < VERTEX_COUNT);
  assign c_ok = (32'(in_index_c) < VERTEX_COUNT);

  assign rd_x = $signed(pos_rd[3*CW-1 -: CW]);
  assign rd_y = $signed(pos_rd[2*CW-1 -: CW]);
  assign rd_z = $signed(pos_rd[CW-1:0]);

  assign pos_we    = accept && (cmd_t'(in_command) == CMD_WRITE) && a_ok;
  assign pos_waddr = AW'(in_index_a);
  assign pos_wdata = {in_pos_x, in_pos_y, in_pos_z};

  assign step_m1 = step_r - STEP_W'(1);
  assign fn_sel  = step_m1[2:1];

  always_comb begin
    case (comp_r)
      2'd0:    corner_addr = AW'(ia_r);
      2'd1:    corner_addr = AW'(ib_r);
      default: corner_addr = AW'(ic_r);
    endcase
  end

  always_comb begin
    case (state_r)
      S_TRB:   pos_raddr = AW'(ib_r);
      S_TRC:   pos_raddr = AW'(ic_r);
      default: pos_raddr = AW'(ia_r);
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_c[k]   = $signed(acc_rd[(3-k)*A-1 -: A]);
      sat_sum[k] = SUM_W'(acc_c[k]) + SUM_W'(fn_r[k]);
      if (sat_sum[k] > ACC_HI) begin
        sat_res[k] = A'(ACC_HI);
      end else if (sat_sum[k] < ACC_LO) begin
        sat_res[k] = A'(ACC_LO);
      end else begin
        sat_res[k] = A'(sat_sum[k]);
      end
    end
  end

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = corner_addr;
    acc_wdata = {sat_res[0], sat_res[1], sat_res[2]};
    acc_raddr = (state_r == S_ARD) ? corner_addr : AW'(ia_r);
    if (state_r == S_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_r;
      acc_wdata = '0;
    end else if (state_r == S_AWR) begin
      acc_we = 1'b1;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_MUL) begin
      case (step_r)
        STEP_W'(0): begin mul_a = MUL_W'(uy_r); mul_b = MUL_W'(vz_r); end
        STEP_W'(1): begin mul_a = MUL_W'(uz_r); mul_b = MUL_W'(vy_r); end
        STEP_W'(2): begin mul_a = MUL_W'(uz_r); mul_b = MUL_W'(vx_r); end
        STEP_W'(3): begin mul_a = MUL_W'(ux_r); mul_b = MUL_W'(vz_r); end
        STEP_W'(4): begin mul_a = MUL_W'(ux_r); mul_b = MUL_W'(vy_r); end
        STEP_W'(5): begin mul_a = MUL_W'(uy_r); mul_b = MUL_W'(vx_r); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == S_RSQ && step_r < STEP_W'(3)) begin
      mul_a = $signed(MUL_W'(mag_r[step_r[1:0]][NORM_BITS-1:0]));
      mul_b = mul_a;
    end
  end

  assign prod_nxt = mul_a * mul_b;

  assign sqrt_t = root_r + bit_r;
  assign div_t  = (step_r == '0) ? (LEN_W+1)'(mag_r[comp_r][NORM_BITS-1:0])
                                 : {rem_r, 1'b0};
  assign div_ge = (div_t >= (LEN_W+1)'(len_r));
  assign q_nxt  = {q_r[NORMAL_W-2:0], div_ge};
  assign q_sat  = q_nxt[NORMAL_W-1] ? {1'b0, {(NORMAL_W-1){1'b1}}} : q_nxt;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    step_nxt  = step_r;
    comp_nxt  = comp_r;
    ia_nxt = ia_r; ib_nxt = ib_r; ic_nxt = ic_r;
    pax_nxt = pax_r; pay_nxt = pay_r; paz_nxt = paz_r;
    ux_nxt = ux_r; uy_nxt = uy_r; uz_nxt = uz_r;
    vx_nxt = vx_r; vy_nxt = vy_r; vz_nxt = vz_r;
    fn_nxt   = fn_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    mmax_nxt = mmax_r;
    sq_nxt   = sq_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    len_nxt  = len_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt = out_idx_r;
    out_x_nxt = out_x_r; out_y_nxt = out_y_r; out_z_nxt = out_z_r;

    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(VERTEX_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          ia_nxt = in_index_a;
          ib_nxt = in_index_b;
          ic_nxt = in_index_c;
          case (cmd_t'(in_command))
            CMD_TRIANGLE: begin
              if (a_ok && b_ok && c_ok) begin
                state_nxt = S_TRA;
              end
            end
            CMD_READ: begin
              if (a_ok) begin
                state_nxt = S_RACC;
              end else begin
                res_nxt   = '{default: '0};
                state_nxt = S_RFIN;
              end
            end
            CMD_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_TRA: state_nxt = S_TRB;
      S_TRB: begin
        pax_nxt = rd_x; pay_nxt = rd_y; paz_nxt = rd_z;
        state_nxt = S_TRC;
      end
      S_TRC: begin
        ux_nxt = DW'(rd_x) - DW'(pax_r);
        uy_nxt = DW'(rd_y) - DW'(pay_r);
        uz_nxt = DW'(rd_z) - DW'(paz_r);
        state_nxt = S_TV;
      end
      S_TV: begin
        vx_nxt = DW'(rd_x) - DW'(pax_r);
        vy_nxt = DW'(rd_y) - DW'(pay_r);
        vz_nxt = DW'(rd_z) - DW'(paz_r);
        step_nxt  = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r != '0) begin
          if (step_m1[0]) begin
            fn_nxt[fn_sel] = fn_r[fn_sel] - FN_W'(prod_r);
          end else begin
            fn_nxt[fn_sel] = FN_W'(prod_r);
          end
        end
        if (step_r == STEP_W'(6)) begin
          comp_nxt  = '0;
          state_nxt = S_ARD;
        end
      end
      S_ARD: state_nxt = S_AWR;
      S_AWR: begin
        if (comp_r == 2'd2) begin
          state_nxt = S_IDLE;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_ARD;
        end
      end
      S_RACC: state_nxt = S_RMAG;
      S_RMAG: begin
        for (int k = 0; k < 3; k++) begin
          neg_nxt[k] = acc_c[k][A-1];
          mag_nxt[k] = acc_c[k][A-1] ? A'(-acc_c[k]) : A'(acc_c[k]);
        end
        mmax_nxt = mag_nxt[0];
        if (mag_nxt[1] > mmax_nxt) mmax_nxt = mag_nxt[1];
        if (mag_nxt[2] > mmax_nxt) mmax_nxt = mag_nxt[2];
        state_nxt = S_RSH;
      end
      S_RSH: begin
        if (|mmax_r[A-1:NORM_BITS]) begin
          for (int k = 0; k < 3; k++) begin
            mag_nxt[k] = mag_r[k] >> 1;
          end
          mmax_nxt = mmax_r >> 1;
        end else begin
          sq_nxt    = '0;
          step_nxt  = '0;
          state_nxt = S_RSQ;
        end
      end
      S_RSQ: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r != '0) begin
          sq_nxt = sq_r + prod_r[SQ_W-1:0];
        end
        if (step_r == STEP_W'(3)) begin
          root_nxt  = '0;
          bit_nxt   = SQ_W'(1) << (2 * NORM_BITS);
          state_nxt = S_RSQRT;
        end
      end
      S_RSQRT: begin
        if (sq_r >= sqrt_t) begin
          sq_nxt   = sq_r - sqrt_t;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          len_nxt  = root_nxt[LEN_W-1:0];
          step_nxt = '0;
          comp_nxt = '0;
          if (root_nxt == '0) begin
            res_nxt   = '{default: '0};
            state_nxt = S_RFIN;
          end else begin
            state_nxt = S_RDIV;
          end
        end
      end
      S_RDIV: begin
        rem_nxt  = div_ge ? LEN_W'(div_t - (LEN_W+1)'(len_r)) : LEN_W'(div_t);
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(NORMAL_W - 1)) begin
          res_nxt[comp_r] = neg_r[comp_r] ? NORMAL_W'(-q_sat) : q_sat;
          step_nxt = '0;
          if (comp_r == 2'd2) begin
            state_nxt = S_RFIN;
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
      end
      S_RFIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = ia_r;
          out_x_nxt     = res_r[0];
          out_y_nxt     = res_r[1];
          out_z_nxt     = res_r[2];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      step_r      <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      step_r      <= step_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= (state_r == S_RDIV && step_r != STEP_W'(NORMAL_W - 1)) ? q_nxt : '0;
    ia_r <= ia_nxt; ib_r <= ib_nxt; ic_r <= ic_nxt;
    pax_r <= pax_nxt; pay_r <= pay_nxt; paz_r <= paz_nxt;
    ux_r <= ux_nxt; uy_r <= uy_nxt; uz_r <= uz_nxt;
    vx_r <= vx_nxt; vy_r <= vy_nxt; vz_r <= vz_nxt;
    fn_r   <= fn_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    mmax_r <= mmax_nxt;
    prod_r <= prod_nxt;
    sq_r   <= sq_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    len_r  <= len_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    out_idx_r <= out_idx_nxt;
    out_x_r <= out_x_nxt; out_y_r <= out_y_nxt; out_z_r <= out_z_nxt;
  end

endmodule

@@ hw/rtl/svnb_checker.sv @@
`timescale 1ns / 1ps
module svnb_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [svnb_pkg::CMD_W-1:0]           in_command,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [svnb_pkg::NORMAL_W-1:0] out_normal_x,
  input logic signed [svnb_pkg::NORMAL_W-1:0] out_normal_y,
  input logic signed [svnb_pkg::NORMAL_W-1:0] out_normal_z
);

  import svnb_pkg::*;

  logic acc_in;
  assign acc_in = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_normal_x))
    else $error("Result item dropped or changed while stalled.");

  a_busy_after_long: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && (in_command == CMD_READ || in_command == CMD_CLEAR) |=> !in_ready)
    else $error("Block ready straight after a read or clear item.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && (in_command == CMD_WRITE || in_command == CMD_TRIANGLE) |=> !$rose(out_valid))
    else $error("Result item produced by a write or triangle item.");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x != 16'sh8000 && out_normal_y != 16'sh8000 &&
                  out_normal_z != 16'sh8000)
    else $error("Normal component outside the saturated range.");

endmodule

bind smooth_vertex_normal_builder svnb_checker u_svnb_checker (.*);
